### design/sbd_pkg.sv
// Shared constants and types for the sonar blip detector.
package sbd_pkg;

  localparam int unsigned HIST_DEPTH = 8;
  localparam int unsigned IDX_W      = $clog2(HIST_DEPTH);
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned THR_W      = 16;

  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HIST_DEPTH - 1);

  // Item kinds carried on the input tuser bit.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_BLIP   = 1'b0;
  localparam logic REG_RETURN = 1'b1;

  typedef enum logic {
    CMP_EDGE   = 1'b0,
    CMP_RETURN = 1'b1
  } cmp_mode_e;

  typedef struct packed {
    cmp_mode_e         mode;
    logic [DIST_W-1:0] opa;
    logic [DIST_W-1:0] opb;
    logic [THR_W-1:0]  thresh;
  } cmp_req_t;

endpackage

### design/sbd_history.sv
// Shift-register history of timestamped distances with one indexed read port.
module sbd_history (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [sbd_pkg::DIST_W-1:0]  dist_i,
  input  logic [sbd_pkg::TIME_W-1:0]  time_i,
  input  logic [sbd_pkg::IDX_W-1:0]   rd_idx_i,
  output logic [sbd_pkg::DIST_W-1:0]  rd_dist_o,
  output logic [sbd_pkg::TIME_W-1:0]  rd_time_o
);
  import sbd_pkg::*;

  logic [DIST_W-1:0] dist_q [HIST_DEPTH];
  logic [TIME_W-1:0] time_q [HIST_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        dist_q[k] <= '0;
        time_q[k] <= '0;
      end
    end else if (push_i) begin
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
        dist_q[k] <= dist_q[k-1];
        time_q[k] <= time_q[k-1];
      end
      dist_q[0] <= dist_i;
      time_q[0] <= time_i;
    end
  end

  assign rd_dist_o = dist_q[rd_idx_i];
  assign rd_time_o = time_q[rd_idx_i];

endmodule

### design/sbd_cmp_unit.sv
// Shared subtract-and-compare unit used by both scan phases.
module sbd_cmp_unit (
  input  sbd_pkg::cmp_req_t req_i,
  output logic              hit_o
);
  import sbd_pkg::*;

  logic [DIST_W:0]   diff;
  logic [DIST_W-1:0] mag;

  always_comb begin
    diff = {1'b0, req_i.opa} - {1'b0, req_i.opb};
    mag  = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
    unique case (req_i.mode)
      // An edge: opa exceeds opb by more than the threshold.
      CMP_EDGE:   hit_o = !diff[DIST_W] && (mag > req_i.thresh);
      CMP_RETURN: hit_o = mag < req_i.thresh;
      default:    hit_o = 1'b0;
    endcase
  end

endmodule

### design/sonar_blip_detector.sv
// Top level of the sonar blip detector: stream ports, registers and scan sequencer.
//
// Input items arrive on the s_axis channel; tuser selects push (0) or query (1),
// tdata carries the distance in mm and the current time in ms. A push shifts the
// eight-entry history and stores the sample; it gives no result. A query walks
// the history with one shared subtract-and-compare unit: first a search for
// the blip edge, one slot per cycle starting at slot 1, then a search for the
// return, one slot per cycle starting at the edge. The result of a query is
// loaded into the output register when done; the input is not ready meanwhile.
// The m_axis channel carries found on tuser and the elapsed time on tdata.
// A waiting result blocks the input: a new item is taken only once the output
// register is empty or being emptied, so a stalled receiver holds off the
// sender but nothing is lost. The thresholds are written through the APB port
// at byte addresses 0 and 4. Reset clears the history to zeros, loads the
// default thresholds of 200 mm and 100 mm, and empties the output register.
module sonar_blip_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] distance_mm, [47:16] now_ms
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] elapsed_ms
  output logic        m_axis_tuser,   // [0] found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EDGE = 3'b010,
    ST_RET  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0]  blip_thr_q, ret_thr_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [DIST_W-1:0] prev_q, prev_d;
  logic [TIME_W-1:0] now_q, edge_time_q;
  logic              out_valid_q, out_found_q;
  logic [TIME_W-1:0] out_elapsed_q;

  logic              in_accept, is_push, is_query, out_free;
  logic [DIST_W-1:0] rd_dist;
  logic [TIME_W-1:0] rd_time;
  logic              hit, last;
  logic              finish, finish_found;
  cmp_req_t          cmp_req;

  logic              reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blip_thr_q <= THR_W'(200);
      ret_thr_q  <= THR_W'(100);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_BLIP:   blip_thr_q <= pwdata[THR_W-1:0];
        REG_RETURN: ret_thr_q  <= pwdata[THR_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLIP:   prdata = {{(32-THR_W){1'b0}}, blip_thr_q};
      REG_RETURN: prdata = {{(32-THR_W){1'b0}}, ret_thr_q};
      default:    prdata = '0;
    endcase
  end

  // Input handshake.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_push       = in_accept && (s_axis_tuser == OP_PUSH);
  assign is_query      = in_accept && (s_axis_tuser == OP_QUERY);

  sbd_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (is_push),
    .dist_i    (s_axis_tdata[DIST_W-1:0]),
    .time_i    (s_axis_tdata[DIST_W +: TIME_W]),
    .rd_idx_i  (idx_q),
    .rd_dist_o (rd_dist),
    .rd_time_o (rd_time)
  );

  // In the edge phase prev_q holds the distance of the slot before idx_q;
  // in the return phase it holds the expected distance.
  always_comb begin
    cmp_req.mode   = (state_q == ST_RET) ? CMP_RETURN : CMP_EDGE;
    cmp_req.opa    = (state_q == ST_RET) ? rd_dist : prev_q;
    cmp_req.opb    = (state_q == ST_RET) ? prev_q : rd_dist;
    cmp_req.thresh = (state_q == ST_RET) ? ret_thr_q : blip_thr_q;
  end

  sbd_cmp_unit u_cmp (
    .req_i (cmp_req),
    .hit_o (hit)
  );

  assign last = (idx_q == IDX_LAST);

  // The read index rests at slot 0 while idle, so a query starts from the newest distance.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    finish       = 1'b0;
    finish_found = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          state_d = ST_EDGE;
          idx_d   = IDX_FIRST;
          prev_d  = rd_dist;
        end
      end
      ST_EDGE: begin
        if (hit) begin
          state_d = ST_RET;
        end else if (last) begin
          state_d = ST_IDLE;
          idx_d   = '0;
          finish  = 1'b1;
        end else begin
          prev_d = rd_dist;
          idx_d  = idx_q + IDX_W'(1);
        end
      end
      ST_RET: begin
        if (hit) begin
          state_d      = ST_IDLE;
          idx_d        = '0;
          finish       = 1'b1;
          finish_found = 1'b1;
        end else if (last) begin
          state_d = ST_IDLE;
          idx_d   = '0;
          finish  = 1'b1;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (is_query) begin
      now_q <= s_axis_tdata[DIST_W +: TIME_W];
    end
    if ((state_q == ST_EDGE) && hit) begin
      edge_time_q <= rd_time;
    end
    if (finish) begin
      out_found_q   <= finish_found;
      out_elapsed_q <= finish_found ? (now_q - edge_time_q) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_elapsed_q;

endmodule
